// ===== hw/rtl/rzs_pkg.sv =====
// rzs_pkg: shared constants for the rolling z-score threshold signal block
// register indexes, signal codes, reset values and default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rzs_pkg;
	localparam int DEF_MAX_WINDOW = 256;
	localparam int FIFO_DEPTH     = 2;
	localparam int PRICE_W        = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_THRESHOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE    = 2'd2;

	localparam logic [1:0] SIG_HOLD = 2'd0;
	localparam logic [1:0] SIG_BUY  = 2'd1;
	localparam logic [1:0] SIG_SELL = 2'd2;

	localparam logic [8:0]  RST_WINDOW_LENGTH = 9'd20;
	localparam logic [15:0] RST_Z_THRESHOLD   = 16'd512;
	localparam logic [31:0] RST_ORDER_SIZE    = 32'd65536;
endpackage
`default_nettype wire

// ===== hw/rtl/rzs_fifo.sv =====
// rzs_fifo: small word queue between the front and back parts
// depends on nothing beyond its parameters
`timescale 1ns / 1ps
`default_nettype none
module rzs_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output logic [W-1:0]      rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;
	logic          push, pop;

	assign wr_ready = (cnt_q != NW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH)) else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count step");
endmodule
`default_nettype wire

// ===== hw/rtl/rzs_front.sv =====
// rzs_front: accepts price words, tracks window pointer and fill count
// and issues one command word per price; uses rzs_pkg
`timescale 1ns / 1ps
`default_nettype none
module rzs_front #(
	parameter int MAX_WINDOW = 256,
	parameter int AW         = 8,
	parameter int CW         = 9,
	parameter int CMD_W      = 51
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [8:0]                  window_length,
	input  wire logic                        clear,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [rzs_pkg::PRICE_W-1:0] price,
	output logic                             cmd_valid,
	input  wire logic                        cmd_ready,
	output logic [CMD_W-1:0]                 cmd
);
	import rzs_pkg::*;

	localparam int LW = (CW > 9) ? CW : 9;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [AW-1:0]      addr;
		logic [CW-1:0]      n;
		logic               full;
		logic               recomp;
	} cmd_t;

	logic [AW-1:0] wp_q, wp_use, wp_nxt;
	logic [CW-1:0] fill_q, fill_nxt, len;
	logic [LW-1:0] wl_ext;
	cmd_t          c;
	logic          acc;

	always_comb begin
		wl_ext = LW'(window_length);
		if (window_length == '0) begin
			len = CW'(1);
		end else if (wl_ext > LW'(MAX_WINDOW)) begin
			len = CW'(MAX_WINDOW);
		end else begin
			len = CW'(wl_ext);
		end
		wp_use   = (CW'(wp_q) >= len) ? '0 : wp_q;
		wp_nxt   = ((CW'(wp_use) + 1'b1) >= len) ? '0 : wp_use + 1'b1;
		fill_nxt = (fill_q < len) ? fill_q + 1'b1 : fill_q;
		c.price  = price;
		c.addr   = wp_use;
		c.n      = fill_nxt;
		c.full   = (fill_nxt == len);
		c.recomp = (fill_nxt >= CW'(2));
	end

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign cmd       = c;
	assign acc       = in_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (clear) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (acc) begin
			wp_q   <= wp_nxt;
			fill_q <= fill_nxt;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rzs_div.sv =====
// rzs_div: restoring divider, one quotient bit per cycle
// shared by the mean, variance and z-score steps; no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rzs_div #(
	parameter int DW = 73
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [31:0]   divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);
	localparam int KW = $clog2(DW + 1);

	logic          busy_q, done_q;
	logic [KW-1:0] cnt_q;
	logic [31:0]   rem_q, d_q;
	logic [DW-1:0] q_q;
	logic [32:0]   sh;
	logic          ge;

	assign sh       = {rem_q, q_q[DW-1]};
	assign ge       = (sh >= {1'b0, d_q});
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				d_q    <= divisor;
				q_q    <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? 32'(sh - {1'b0, d_q}) : sh[31:0];
				q_q   <= {q_q[DW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rzs_back.sv =====
// rzs_back: price window memory and the statistics sequencer
// two passes over the window, divides, square root, decision; uses rzs_pkg
`timescale 1ns / 1ps
`default_nettype none
module rzs_back #(
	parameter int MAX_WINDOW = 256,
	parameter int AW         = 8,
	parameter int CW         = 9,
	parameter int CMD_W      = 51,
	parameter int DW         = 73
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire logic [CMD_W-1:0]     cmd,
	input  wire logic [15:0]          z_threshold,
	input  wire logic [31:0]          order_size,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                signal,
	output logic [31:0]               size,
	output logic signed [31:0]        z_score,
	output logic [31:0]               mean,
	output logic [31:0]               std_dev,
	output logic                      window_full,
	output logic                      div_start,
	output logic [DW-1:0]             div_dividend,
	output logic [31:0]               div_divisor,
	input  wire logic                 div_done,
	input  wire logic [DW-1:0]        div_quotient
);
	import rzs_pkg::*;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [AW-1:0]      addr;
		logic [CW-1:0]      n;
		logic               full;
		logic               recomp;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SUM, S_MEAN, S_SQ, S_VAR, S_SQRT, S_ZDIV, S_OUT
	} state_t;

	state_t        state_q;
	cmd_t          c;
	logic [31:0]   mem [MAX_WINDOW];
	logic [31:0]   rd_q;
	logic [CW-1:0] cnt_q, n_q, nm1;
	logic          p1_q, p2_q, p3_q;
	logic [31+CW:0] sum_q;
	logic [DW-1:0] acc_q;
	logic [31:0]   mean_q, sd_q, z_q, price_q, diff_s2;
	logic [63:0]   sq_s3, sqv_q;
	logic          full_q, sat_q, neg_q;
	logic [33:0]   sqrem_q;
	logic [31:0]   root_q, root_n;
	logic [34:0]   remsh, trial;
	logic [33:0]   rem_n;
	logic [4:0]    it_q;
	logic [31:0]   mag;
	logic [32:0]   zx, thrx;
	logic          buy, sell;
	logic [DW-1:0] q;
	logic          div_go;
	logic          ovalid_q;
	logic [1:0]    sig_q;
	logic [31:0]   size_q, zo_q, mo_q, so_q;
	logic          fo_q;

	assign c         = cmd;
	assign cmd_ready = (state_q == S_IDLE);
	assign nm1       = n_q - 1'b1;
	assign q         = div_quotient;
	assign div_go    = (state_q == S_SUM && cnt_q == n_q && !p1_q) ||
		(state_q == S_SQ && cnt_q == n_q && !p1_q && !p2_q && !p3_q) ||
		(state_q == S_SQRT && it_q == 5'd31 && root_n != '0);

	always_comb begin
		remsh = {sqrem_q[32:0], sqv_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		if (remsh >= trial) begin
			rem_n  = 34'(remsh - trial);
			root_n = {root_q[30:0], 1'b1};
		end else begin
			rem_n  = remsh[33:0];
			root_n = {root_q[30:0], 1'b0};
		end
		mag  = (price_q < mean_q) ? mean_q - price_q : price_q - mean_q;
		zx   = {z_q[31], z_q};
		thrx = {9'b0, z_threshold, 8'b0};
		buy  = $signed(zx) < -$signed(thrx);
		sell = $signed(zx) > $signed(thrx);
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			mem[c.addr] <= c.price;
		end
		rd_q <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			n_q          <= '0;
			p1_q         <= 1'b0;
			p2_q         <= 1'b0;
			p3_q         <= 1'b0;
			sum_q        <= '0;
			acc_q        <= '0;
			mean_q       <= '0;
			sd_q         <= '0;
			z_q          <= '0;
			price_q      <= '0;
			diff_s2      <= '0;
			sq_s3        <= '0;
			sqv_q        <= '0;
			full_q       <= 1'b0;
			sat_q        <= 1'b0;
			neg_q        <= 1'b0;
			sqrem_q      <= '0;
			root_q       <= '0;
			it_q         <= '0;
			div_start    <= 1'b0;
			div_dividend <= '0;
			div_divisor  <= '0;
			ovalid_q     <= 1'b0;
			sig_q        <= SIG_HOLD;
			size_q       <= '0;
			zo_q         <= '0;
			mo_q         <= '0;
			so_q         <= '0;
			fo_q         <= 1'b0;
		end else begin
			div_start <= div_go;
			if (state_q == S_OUT && (!ovalid_q || out_ready)) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						price_q <= c.price;
						n_q     <= c.n;
						full_q  <= c.full;
						cnt_q   <= '0;
						sum_q   <= '0;
						p1_q    <= 1'b0;
						state_q <= c.recomp ? S_SUM : S_OUT;
					end
				end
				S_SUM: begin
					p1_q <= (cnt_q < n_q);
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (p1_q) begin
						sum_q <= sum_q + (32 + CW)'(rd_q);
					end
					if (cnt_q == n_q && !p1_q) begin
						div_dividend <= DW'(sum_q);
						div_divisor  <= 32'(n_q);
						state_q      <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						mean_q  <= q[31:0];
						cnt_q   <= '0;
						acc_q   <= '0;
						p1_q    <= 1'b0;
						p2_q    <= 1'b0;
						p3_q    <= 1'b0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					p1_q <= (cnt_q < n_q);
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					p2_q <= p1_q;
					p3_q <= p2_q;
					if (p1_q) begin
						diff_s2 <= (rd_q >= mean_q) ? rd_q - mean_q : mean_q - rd_q;
					end
					if (p2_q) begin
						sq_s3 <= diff_s2 * diff_s2;
					end
					if (p3_q) begin
						acc_q <= acc_q + DW'(sq_s3);
					end
					if (cnt_q == n_q && !p1_q && !p2_q && !p3_q) begin
						sat_q        <= (acc_q[DW-1:64] >= nm1);
						div_dividend <= acc_q;
						div_divisor  <= 32'(nm1);
						state_q      <= S_VAR;
					end
				end
				S_VAR: begin
					if (div_done) begin
						sqv_q   <= sat_q ? '1 : q[63:0];
						sqrem_q <= '0;
						root_q  <= '0;
						it_q    <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					sqrem_q <= rem_n;
					root_q  <= root_n;
					sqv_q   <= {sqv_q[61:0], 2'b00};
					it_q    <= it_q + 1'b1;
					if (it_q == 5'd31) begin
						sd_q <= root_n;
						if (root_n == '0) begin
							state_q <= S_OUT;
						end else begin
							neg_q        <= (price_q < mean_q);
							div_dividend <= DW'({mag, 16'b0});
							div_divisor  <= root_n;
							state_q      <= S_ZDIV;
						end
					end
				end
				S_ZDIV: begin
					if (div_done) begin
						if (neg_q) begin
							z_q <= (|q[DW-1:31]) ? 32'h8000_0000 : 32'(-q[31:0]);
						end else begin
							z_q <= (|q[DW-1:31]) ? 32'h7FFF_FFFF : q[31:0];
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q || out_ready) begin
						if (full_q && buy) begin
							sig_q  <= SIG_BUY;
							size_q <= order_size;
						end else if (full_q && sell) begin
							sig_q  <= SIG_SELL;
							size_q <= order_size;
						end else begin
							sig_q  <= SIG_HOLD;
							size_q <= '0;
						end
						zo_q    <= z_q;
						mo_q    <= mean_q;
						so_q    <= sd_q;
						fo_q    <= full_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = ovalid_q;
	assign signal      = sig_q;
	assign size        = size_q;
	assign z_score     = zo_q;
	assign mean        = mo_q;
	assign std_dev     = so_q;
	assign window_full = fo_q;

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_MEAN || state_q == S_VAR || state_q == S_ZDIV))
		else $error("divider finished outside a divide step");
	a_trade_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && sig_q != SIG_HOLD) |-> fo_q)
		else $error("trade signalled on a partial window");
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && sig_q == SIG_HOLD) |-> (size_q == '0))
		else $error("hold word with non-zero size");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ready) |=> ovalid_q)
		else $error("result word dropped");
endmodule
`default_nettype wire

// ===== hw/rtl/rolling_zscore_threshold_signal.sv =====
// Rolling z-score threshold signal: one result word per price word. The
// front keeps the window pointer and fill count and queues a command per
// price; the back writes the price to the window memory and, once two or
// more prices are held, makes a summing pass and a squared-deviation pass
// over the n held prices, then runs restoring divides for the mean, the
// variance and, unless the deviation is zero, the z-score on one shared
// divider, with a 32-step square root. The back takes a new command only
// when idle, paced by the window memory's single read port and the
// bit-serial divider; with fewer than two prices it skips these steps.
// Writing window_length empties the window.
`timescale 1ns / 1ps
`default_nettype none
module rolling_zscore_threshold_signal #(
	parameter int MAX_WINDOW = rzs_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rzs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rzs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rzs_pkg::PRICE_W-1:0]    price,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          signal,
	output logic [31:0]                         size,
	output logic signed [31:0]                  z_score,
	output logic [31:0]                         mean,
	output logic [31:0]                         std_dev,
	output logic                                window_full
);
	import rzs_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int CW    = $clog2(MAX_WINDOW + 1);
	localparam int CMD_W = PRICE_W + AW + CW + 2;
	localparam int DW    = 64 + CW;

	logic [8:0]       window_length_q;
	logic [15:0]      z_threshold_q;
	logic [31:0]      order_size_q;
	logic             clear;
	logic             f_valid, f_ready, b_valid, b_ready;
	logic [CMD_W-1:0] f_cmd, b_cmd;
	logic             div_start, div_done;
	logic [DW-1:0]    div_dividend, div_quotient;
	logic [31:0]      div_divisor;

	assign clear = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= RST_WINDOW_LENGTH;
			z_threshold_q   <= RST_Z_THRESHOLD;
			order_size_q    <= RST_ORDER_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[8:0];
				REG_Z_THRESHOLD:   z_threshold_q   <= cfg_data[15:0];
				REG_ORDER_SIZE:    order_size_q    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	rzs_front #(
		.MAX_WINDOW(MAX_WINDOW), .AW(AW), .CW(CW), .CMD_W(CMD_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.window_length(window_length_q), .clear(clear),
		.in_valid(in_valid), .in_ready(in_ready), .price(price),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	rzs_fifo #(.W(CMD_W), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	rzs_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n),
		.start(div_start), .dividend(div_dividend), .divisor(div_divisor),
		.done(div_done), .quotient(div_quotient)
	);

	rzs_back #(
		.MAX_WINDOW(MAX_WINDOW), .AW(AW), .CW(CW), .CMD_W(CMD_W), .DW(DW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.z_threshold(z_threshold_q), .order_size(order_size_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.signal(signal), .size(size), .z_score(z_score), .mean(mean),
		.std_dev(std_dev), .window_full(window_full),
		.div_start(div_start), .div_dividend(div_dividend),
		.div_divisor(div_divisor), .div_done(div_done),
		.div_quotient(div_quotient)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb_rolling_zscore_threshold_signal.sv =====
// tb_rolling_zscore_threshold_signal: self-checking testbench for the rolling z-score block
// a clocked driver and monitor, a bit-true predictor of window, statistics and signal
// depends on rzs_pkg and rolling_zscore_threshold_signal
`timescale 1ns / 1ps
module tb_rolling_zscore_threshold_signal;
	import rzs_pkg::*;

	localparam int MAXW = DEF_MAX_WINDOW;
	localparam int STALL_LIMIT = 20000;
	localparam int QDEPTH = 2048;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  sig;
		logic [31:0] size;
		logic [31:0] z;
		logic [31:0] mean;
		logic [31:0] sd;
		logic        full;
	} zs_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PRICE_W-1:0] price = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] signal;
	logic [31:0] size;
	logic signed [31:0] z_score;
	logic [31:0] mean;
	logic [31:0] std_dev;
	logic window_full;

	rolling_zscore_threshold_signal uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .price(price),
		.out_valid(out_valid), .out_ready(out_ready),
		.signal(signal), .size(size), .z_score(z_score), .mean(mean),
		.std_dev(std_dev), .window_full(window_full)
	);

	// predictor state
	logic [8:0]  m_len_reg = RST_WINDOW_LENGTH;
	logic [15:0] m_thr = RST_Z_THRESHOLD;
	logic [31:0] m_osz = RST_ORDER_SIZE;
	logic [31:0] m_win [MAXW];
	int unsigned m_wptr = 0;
	int unsigned m_fill = 0;
	logic [31:0] m_mean = '0;
	logic [31:0] m_sd = '0;
	logic [31:0] m_z = '0;

	logic [31:0] price_buf [QDEPTH];
	int price_wr = 0;
	int price_rd = 0;
	zs_result_t  res_buf [QDEPTH];
	int res_wr = 0;
	int res_rd = 0;
	int errors = 0;
	int n_words = 0;
	int n_buy = 0;
	int n_sell = 0;
	int n_full = 0;
	logic in_taken = 1'b0;
	logic no_idle = 1'b0;
	int stall = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void put_price(input logic [31:0] p);
		price_buf[price_wr] = p;
		price_wr++;
	endfunction

	function automatic logic [31:0] floor_root(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] t;
		int b;
		res = '0;
		for (b = 31; b >= 0; b--) begin
			t = res | (64'd1 << b);
			if (t * t <= v) res = t;
		end
		return res[31:0];
	endfunction

	function automatic void model_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		case (idx)
			REG_WINDOW_LENGTH: begin
				m_len_reg = data[8:0];
				m_fill = 0;
				m_wptr = 0;
			end
			REG_Z_THRESHOLD: m_thr = data[15:0];
			REG_ORDER_SIZE: m_osz = data;
			default: ;
		endcase
	endfunction

	function automatic zs_result_t predict_word(input logic [31:0] p);
		zs_result_t r;
		int unsigned len;
		int unsigned n;
		int i;
		logic [47:0] sum;
		logic [127:0] sq_sum;
		logic [127:0] qw;
		logic [63:0] dv;
		logic [63:0] var_q;
		logic [63:0] mag;
		logic [63:0] q;
		logic neg;
		longint zs;
		longint thr;
		len = (m_len_reg == 0) ? 1 : ((m_len_reg > MAXW) ? MAXW : m_len_reg);
		if (m_wptr >= len) m_wptr = 0;
		m_win[m_wptr] = p;
		m_wptr = (m_wptr + 1 >= len) ? 0 : m_wptr + 1;
		if (m_fill < len) m_fill++;
		n = m_fill;
		if (n >= 2) begin
			sum = '0;
			for (i = 0; i < n; i++) sum += m_win[i];
			m_mean = 32'(sum / n);
			sq_sum = '0;
			for (i = 0; i < n; i++) begin
				dv = (m_win[i] >= m_mean) ? 64'(m_win[i] - m_mean) : 64'(m_mean - m_win[i]);
				sq_sum += 128'(dv * dv);
			end
			qw = sq_sum / 128'(n - 1);
			var_q = (qw[127:64] != 0) ? {64{1'b1}} : qw[63:0];
			m_sd = floor_root(var_q);
			if (m_sd != 0) begin
				neg = p < m_mean;
				mag = neg ? 64'(m_mean - p) : 64'(p - m_mean);
				q = (mag << 16) / 64'(m_sd);
				if (neg) m_z = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0) - q[31:0];
				else m_z = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			end
		end
		r.sig = SIG_HOLD;
		r.size = '0;
		r.full = (m_fill == len);
		if (r.full) begin
			zs = longint'($signed(m_z));
			thr = longint'(m_thr) * 256;
			if (zs < -thr) begin
				r.sig = SIG_BUY;
				r.size = m_osz;
			end else if (zs > thr) begin
				r.sig = SIG_SELL;
				r.size = m_osz;
			end
		end
		r.z = m_z;
		r.mean = m_mean;
		r.sd = m_sd;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at word %0d: %s got %h expected %h", n_words, what, got, want);
		errors++;
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
			if (!in_valid || in_taken) begin
				if (price_rd != price_wr && (no_idle || $urandom_range(0, 99) >= 26)) begin
					price <= price_buf[price_rd];
					price_rd <= price_rd + 1;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		zs_result_t w;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			res_buf[res_wr] = predict_word(price);
			res_wr++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (res_rd == res_wr) begin
				$display("unexpected result word %0d", n_words);
				errors++;
			end else begin
				w = res_buf[res_rd];
				res_rd++;
				if (signal != w.sig) report_mismatch("signal", 32'(signal), 32'(w.sig));
				if (size != w.size) report_mismatch("size", size, w.size);
				if (z_score != w.z) report_mismatch("z_score", z_score, w.z);
				if (mean != w.mean) report_mismatch("mean", mean, w.mean);
				if (std_dev != w.sd) report_mismatch("std_dev", std_dev, w.sd);
				if (window_full != w.full)
					report_mismatch("window_full", 32'(window_full), 32'(w.full));
			end
			n_words++;
			if (signal == SIG_BUY) n_buy++;
			if (signal == SIG_SELL) n_sell++;
			if (window_full) n_full++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) stall <= 0;
		else stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", res_wr - res_rd);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		model_config(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = $urandom;
	endtask

	task automatic wait_idle();
		while (price_rd != price_wr || in_valid || res_rd != res_wr) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] gen_price(input logic [31:0] base, input int k,
			input bit wild);
		if (wild || $urandom_range(0, 19) == 0) return $urandom;
		return base + ($urandom & ((32'd1 << k) - 1));
	endfunction

	task automatic run_phase(input logic [8:0] wl, input logic [15:0] thr,
			input logic [31:0] osz, input int count, input bit wild);
		logic [31:0] base;
		int k;
		int i;
		base = $urandom;
		k = $urandom_range(2, 24);
		cfg_write(REG_WINDOW_LENGTH, {$urandom} & 32'hFFFF_FE00 | 32'(wl));
		cfg_write(REG_Z_THRESHOLD, {$urandom} & 32'hFFFF_0000 | 32'(thr));
		cfg_write(REG_ORDER_SIZE, osz);
		for (i = 0; i < count; i++) put_price(gen_price(base, k, wild));
		wait_idle();
	endtask

	function automatic logic [15:0] pick_thr();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 1024));
		endcase
	endfunction

	initial begin
		int ph;
		int wl;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults, fewer than two prices then a few more
		put_price(32'd0);
		put_price(32'hFFFF_FFFF);
		put_price(32'h0001_0000);
		wait_idle();
		cfg_write(REG_NONE, $urandom);
		// length zero acts as one
		cfg_write(REG_WINDOW_LENGTH, 32'd0);
		put_price(32'h1234_5678);
		put_price(32'hFFFF_FFFF);
		wait_idle();
		// length two, zero threshold, extremes and zero deviation
		cfg_write(REG_WINDOW_LENGTH, 32'd2);
		cfg_write(REG_Z_THRESHOLD, 32'd0);
		cfg_write(REG_ORDER_SIZE, 32'hFFFF_FFFF);
		put_price(32'd0);
		put_price(32'hFFFF_FFFF);
		put_price(32'hFFFF_FFFF);
		put_price(32'd0);
		put_price(32'd5);
		put_price(32'd5);
		put_price(32'd5);
		wait_idle();
		// length three, largest threshold
		cfg_write(REG_WINDOW_LENGTH, 32'd3);
		cfg_write(REG_Z_THRESHOLD, 32'hFFFF);
		cfg_write(REG_ORDER_SIZE, 32'd0);
		put_price(32'd1);
		put_price(32'd2);
		put_price(32'hFFFF_FFFF);
		put_price(32'd0);
		put_price(32'd0);
		put_price(32'hFFFF_FFFF);
		wait_idle();

		// random phases, mostly short windows
		for (ph = 0; ph < 16; ph++) begin
			case ($urandom_range(0, 4))
				0: wl = $urandom_range(0, 2);
				1: wl = $urandom_range(3, 8);
				default: wl = $urandom_range(4, 24);
			endcase
			no_idle = (ph == 5);
			cfg_write(REG_NONE, $urandom);
			run_phase(9'(wl), pick_thr(), $urandom, $urandom_range(12, 30), ph % 7 == 3);
		end
		no_idle = 1'b0;
		// longest window filled, and an over-range length
		run_phase(9'd256, 16'($urandom_range(0, 512)), $urandom, 270, 1'b0);
		run_phase(9'h1FF, pick_thr(), $urandom, 20, 1'b0);
		run_phase(9'd20, 16'd256, 32'h0001_0000, 30, 1'b0);

		repeat (50) @(posedge clk);
		$display("%0d result words checked: %0d with a full window, %0d buy, %0d sell",
			n_words, n_full, n_buy, n_sell);
		$display("window lengths 0 to 24, 256 and over-range 511, thresholds 0 to 65535");
		if (errors == 0 && res_rd == res_wr) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d errors, %0d words never arrived", errors, res_wr - res_rd);
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
